@@ rtl/core/ifr_pkg.sv @@
// Shared constants and helpers for the image fit rectangle block.
// Used by ifr_front, ifr_back and image_fit_rect; depends on nothing else.
package ifr_pkg;

  // Width of the signed span offsets and of the mode register.
  localparam int unsigned OFF_W  = 16;
  localparam int unsigned MODE_W = 3;

  // Fit mode codes. Codes above MODE_ZOOM behave as MODE_ZOOM.
  localparam logic [MODE_W-1:0] MODE_NONE      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TILED     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STRETCHED = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CENTERED  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SCALED    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ZOOM      = 3'd5;

  // Configuration port layout.
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned REG_FIT_MODE = 0;

  // Quotient bits resolved per divider pipeline stage.
  localparam int unsigned DIV_STEP_BITS = 2;

  // Entries of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Bit width of one classified request passed from front to back.
  function automatic int unsigned item_width(input int unsigned dim_bits,
                                             input int unsigned frac_bits);
    return 3 + 3 * (2 * dim_bits + frac_bits) + 3 * dim_bits + 2 * OFF_W;
  endfunction

endpackage

@@ rtl/core/ifr_front.sv @@
// Front part: takes requests, forms the two cross products and classifies
// each request by fit mode. Depends on ifr_pkg.
module ifr_front #(
  parameter int unsigned DIM_BITS  = 14,
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned ITEM_W    = ifr_pkg::item_width(DIM_BITS, FRAC_BITS)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [DIM_BITS-1:0]               source_width_i,
  input  logic [DIM_BITS-1:0]               source_height_i,
  input  logic signed [ifr_pkg::OFF_W-1:0]  span_offset_x_i,
  input  logic signed [ifr_pkg::OFF_W-1:0]  span_offset_y_i,
  input  logic [DIM_BITS-1:0]               span_width_i,
  input  logic [DIM_BITS-1:0]               span_height_i,
  input  logic [ifr_pkg::MODE_W-1:0]        mode_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output logic [ITEM_W-1:0]                 item_o
);
  import ifr_pkg::*;

  localparam int unsigned SIZE_W = 2 * DIM_BITS + FRAC_BITS;
  localparam int unsigned PROD_W = 2 * DIM_BITS;

  typedef struct packed {
    logic                     zero;
    logic                     div_en;
    logic                     div_h;
    logic [SIZE_W-1:0]        w_fix;
    logic [SIZE_W-1:0]        h_fix;
    logic [SIZE_W-1:0]        dividend;
    logic [DIM_BITS-1:0]      divisor;
    logic [DIM_BITS-1:0]      pw;
    logic [DIM_BITS-1:0]      ph;
    logic signed [OFF_W-1:0]  ox;
    logic signed [OFF_W-1:0]  oy;
  } item_t;

  logic                    accept;
  logic                    a_valid_d, a_valid_q;
  logic [DIM_BITS-1:0]     a_sw_q, a_sh_q, a_pw_q, a_ph_q;
  logic signed [OFF_W-1:0] a_ox_q, a_oy_q;
  logic [MODE_W-1:0]       a_mode_q;
  logic [PROD_W-1:0]       a_pws_q, a_phs_q;
  logic                    width_smaller;
  logic                    use_width;
  item_t                   item;

  // The stage holds its request only while the queue is full.
  assign busy_o    = a_valid_q & q_full_i;
  assign accept    = start_i & ~busy_o;
  assign a_valid_d = accept | (a_valid_q & q_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_sw_q   <= source_width_i;
      a_sh_q   <= source_height_i;
      a_pw_q   <= span_width_i;
      a_ph_q   <= span_height_i;
      a_ox_q   <= span_offset_x_i;
      a_oy_q   <= span_offset_y_i;
      a_mode_q <= mode_i;
      a_pws_q  <= PROD_W'(span_width_i) * PROD_W'(source_height_i);
      a_phs_q  <= PROD_W'(span_height_i) * PROD_W'(source_width_i);
    end
  end

  // The width ratio is the smaller one when pw*sh <= ph*sw.
  assign width_smaller = (a_pws_q <= a_phs_q);
  assign use_width     = (a_mode_q == MODE_SCALED) ? width_smaller : ~width_smaller;

  always_comb begin
    item          = '0;
    item.pw       = a_pw_q;
    item.ph       = a_ph_q;
    item.ox       = a_ox_q;
    item.oy       = a_oy_q;
    item.zero     = (a_sw_q == '0) | (a_sh_q == '0);
    unique case (a_mode_q) inside
      MODE_NONE, MODE_TILED: begin
        item.zero = 1'b1;
      end
      MODE_STRETCHED: begin
        item.w_fix = SIZE_W'(a_pw_q) << FRAC_BITS;
        item.h_fix = SIZE_W'(a_ph_q) << FRAC_BITS;
      end
      MODE_CENTERED: begin
        item.w_fix = SIZE_W'(a_sw_q) << FRAC_BITS;
        item.h_fix = SIZE_W'(a_sh_q) << FRAC_BITS;
      end
      default: begin
        item.div_en = 1'b1;
        if (use_width) begin
          item.div_h    = 1'b1;
          item.w_fix    = SIZE_W'(a_pw_q) << FRAC_BITS;
          item.dividend = SIZE_W'(a_pws_q) << FRAC_BITS;
          item.divisor  = a_sw_q;
        end else begin
          item.div_h    = 1'b0;
          item.h_fix    = SIZE_W'(a_ph_q) << FRAC_BITS;
          item.dividend = SIZE_W'(a_phs_q) << FRAC_BITS;
          item.divisor  = a_sh_q;
        end
      end
    endcase
  end

  assign push_o = a_valid_q;
  assign item_o = item;

endmodule

@@ rtl/core/ifr_queue.sv @@
// Short first-in first-out queue that decouples the front and back parts.
// Depends on nothing else; width and depth are set by the instantiating module.
module ifr_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/ifr_back.sv @@
// Back part: pipelined restoring divider for the scaled side, then centering
// in the span and the origin shift. Depends on ifr_pkg.
module ifr_back #(
  parameter int unsigned DIM_BITS  = 14,
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned ITEM_W    = ifr_pkg::item_width(DIM_BITS, FRAC_BITS)
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  logic [ITEM_W-1:0]                       item_i,
  output logic                                    pop_o,
  output logic                                    done_o,
  output logic signed [2*DIM_BITS+FRAC_BITS:0]    dest_x_o,
  output logic signed [2*DIM_BITS+FRAC_BITS:0]    dest_y_o,
  output logic [2*DIM_BITS+FRAC_BITS-1:0]         dest_width_o,
  output logic [2*DIM_BITS+FRAC_BITS-1:0]         dest_height_o
);
  import ifr_pkg::*;

  localparam int unsigned SIZE_W = 2 * DIM_BITS + FRAC_BITS;
  localparam int unsigned POS_W  = SIZE_W + 1;
  localparam int unsigned STAGES = (SIZE_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int unsigned DW     = STAGES * DIV_STEP_BITS;

  typedef struct packed {
    logic                     zero;
    logic                     div_en;
    logic                     div_h;
    logic [SIZE_W-1:0]        w_fix;
    logic [SIZE_W-1:0]        h_fix;
    logic [SIZE_W-1:0]        dividend;
    logic [DIM_BITS-1:0]      divisor;
    logic [DIM_BITS-1:0]      pw;
    logic [DIM_BITS-1:0]      ph;
    logic signed [OFF_W-1:0]  ox;
    logic signed [OFF_W-1:0]  oy;
  } item_t;

  item_t               it_in;
  logic                st_valid_q [STAGES+1];
  logic [DIM_BITS-1:0] st_rem_q   [STAGES+1];
  logic [DW-1:0]       st_dq_q    [STAGES+1];
  item_t               st_item_q  [STAGES+1];

  // The back part never stalls, so every queued request is taken at once.
  assign pop_o = valid_i;
  assign it_in = item_t'(item_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q[0] <= 1'b0;
    end else begin
      st_valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_rem_q[0]  <= '0;
    st_dq_q[0]   <= DW'(it_in.dividend);
    st_item_q[0] <= it_in;
  end

  // Each stage shifts dividend bits into the remainder and shifts quotient
  // bits in at the bottom of the same register.
  for (genvar s = 0; s < STAGES; s++) begin : g_div
    logic [DIM_BITS-1:0] rem_d;
    logic [DW-1:0]       dq_d;

    always_comb begin
      logic [DIM_BITS:0] trial;
      rem_d = st_rem_q[s];
      dq_d  = st_dq_q[s];
      trial = '0;
      for (int k = 0; k < DIV_STEP_BITS; k++) begin
        trial = {rem_d, dq_d[DW-1]};
        dq_d  = {dq_d[DW-2:0], 1'b0};
        if (trial >= {1'b0, st_item_q[s].divisor}) begin
          trial   = trial - {1'b0, st_item_q[s].divisor};
          dq_d[0] = 1'b1;
        end
        rem_d = trial[DIM_BITS-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_valid_q[s+1] <= 1'b0;
      end else begin
        st_valid_q[s+1] <= st_valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      st_rem_q[s+1]  <= rem_d;
      st_dq_q[s+1]   <= dq_d;
      st_item_q[s+1] <= st_item_q[s];
    end
  end

  // Finish stage: pick the sizes and halve the leftover span.
  item_t                   it_end;
  logic [SIZE_W-1:0]       quo;
  logic [SIZE_W-1:0]       w_d, h_d, span_w, span_h;
  logic signed [POS_W-1:0] diff_x, diff_y;

  logic                    fin_valid_q, fin_zero_q;
  logic [SIZE_W-1:0]       fin_w_q, fin_h_q;
  logic signed [POS_W-1:0] fin_hx_q, fin_hy_q;
  logic signed [OFF_W-1:0] fin_ox_q, fin_oy_q;

  assign it_end = st_item_q[STAGES];
  assign quo    = st_dq_q[STAGES][SIZE_W-1:0];
  assign span_w = SIZE_W'(it_end.pw) << FRAC_BITS;
  assign span_h = SIZE_W'(it_end.ph) << FRAC_BITS;

  always_comb begin
    w_d = it_end.w_fix;
    h_d = it_end.h_fix;
    if (it_end.div_en) begin
      if (it_end.div_h) begin
        h_d = quo;
      end else begin
        w_d = quo;
      end
    end
    if (it_end.zero) begin
      w_d = '0;
      h_d = '0;
    end
  end

  assign diff_x = $signed({1'b0, span_w}) - $signed({1'b0, w_d});
  assign diff_y = $signed({1'b0, span_h}) - $signed({1'b0, h_d});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else begin
      fin_valid_q <= st_valid_q[STAGES];
    end
  end

  // An arithmetic shift gives the floor of the half for negative leftovers.
  always_ff @(posedge clk_i) begin
    fin_zero_q <= it_end.zero;
    fin_w_q    <= w_d;
    fin_h_q    <= h_d;
    fin_hx_q   <= diff_x >>> 1;
    fin_hy_q   <= diff_y >>> 1;
    fin_ox_q   <= it_end.ox;
    fin_oy_q   <= it_end.oy;
  end

  // Output stage: subtract the span origin.
  logic signed [POS_W-1:0] off_x, off_y, x_d, y_d;
  logic                    done_q;
  logic signed [POS_W-1:0] dest_x_q, dest_y_q;
  logic [SIZE_W-1:0]       dest_w_q, dest_h_q;

  assign off_x = POS_W'(fin_ox_q) <<< FRAC_BITS;
  assign off_y = POS_W'(fin_oy_q) <<< FRAC_BITS;
  assign x_d   = fin_zero_q ? '0 : fin_hx_q - off_x;
  assign y_d   = fin_zero_q ? '0 : fin_hy_q - off_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dest_x_q <= x_d;
    dest_y_q <= y_d;
    dest_w_q <= fin_w_q;
    dest_h_q <= fin_h_q;
  end

  assign done_o        = done_q;
  assign dest_x_o      = dest_x_q;
  assign dest_y_o      = dest_y_q;
  assign dest_width_o  = dest_w_q;
  assign dest_height_o = dest_h_q;

endmodule

@@ rtl/core/image_fit_rect.sv @@
// Destination rectangle of an image fitted into a span, per configured mode.
// A request passes the front stage, the queue, the divider input register,
// the divider stages, the finish and the output stage. The divider resolves
// two quotient bits per stage. Throughput: one request per cycle unless busy.
// Reset clears all valid flags and the queue and sets fit_mode to zoom fill.
// The receiver cannot stall; each result is shown for one cycle with done_o.
module image_fit_rect #(
  parameter int unsigned DIM_BITS  = 14,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [DIM_BITS-1:0]                   source_width_i,
  input  logic [DIM_BITS-1:0]                   source_height_i,
  input  logic signed [ifr_pkg::OFF_W-1:0]      span_offset_x_i,
  input  logic signed [ifr_pkg::OFF_W-1:0]      span_offset_y_i,
  input  logic [DIM_BITS-1:0]                   span_width_i,
  input  logic [DIM_BITS-1:0]                   span_height_i,
  output logic                                  done_o,
  output logic signed [2*DIM_BITS+FRAC_BITS:0]  dest_x_o,
  output logic signed [2*DIM_BITS+FRAC_BITS:0]  dest_y_o,
  output logic [2*DIM_BITS+FRAC_BITS-1:0]       dest_width_o,
  output logic [2*DIM_BITS+FRAC_BITS-1:0]       dest_height_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ifr_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [ifr_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [ifr_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);
  import ifr_pkg::*;

  localparam int unsigned ITEM_W = item_width(DIM_BITS, FRAC_BITS);
  localparam int unsigned IDX_W  = APB_ADDR_W - 2;

  logic [MODE_W-1:0] fit_mode_q;
  logic [IDX_W-1:0]  reg_idx;
  logic              reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign reg_wr  = psel & penable & pwrite & pready & (reg_idx == IDX_W'(REG_FIT_MODE));
  assign prdata  = (reg_idx == IDX_W'(REG_FIT_MODE)) ? APB_DATA_W'(fit_mode_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= MODE_ZOOM;
    end else if (reg_wr) begin
      fit_mode_q <= pwdata[MODE_W-1:0];
    end
  end

  logic              push, q_full, q_valid, q_pop;
  logic [ITEM_W-1:0] push_item, q_item;

  ifr_front #(
    .DIM_BITS  (DIM_BITS),
    .FRAC_BITS (FRAC_BITS),
    .ITEM_W    (ITEM_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .source_width_i  (source_width_i),
    .source_height_i (source_height_i),
    .span_offset_x_i (span_offset_x_i),
    .span_offset_y_i (span_offset_y_i),
    .span_width_i    (span_width_i),
    .span_height_i   (span_height_i),
    .mode_i          (fit_mode_q),
    .q_full_i        (q_full),
    .push_o          (push),
    .item_o          (push_item)
  );

  ifr_queue #(
    .W     (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_item)
  );

  ifr_back #(
    .DIM_BITS  (DIM_BITS),
    .FRAC_BITS (FRAC_BITS),
    .ITEM_W    (ITEM_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .item_i        (q_item),
    .pop_o         (q_pop),
    .done_o        (done_o),
    .dest_x_o      (dest_x_o),
    .dest_y_o      (dest_y_o),
    .dest_width_o  (dest_width_o),
    .dest_height_o (dest_height_o)
  );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for image_fit_rect: requests, predicted rectangles
// and APB writes of the fit mode. Depends on ifr_pkg and the image_fit_rect RTL.
module tb_top;
  import ifr_pkg::*;

  localparam int unsigned DIM_W    = 14;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned POS_W    = 2 * DIM_W + FRAC_W + 1;
  localparam int unsigned SIZE_W   = 2 * DIM_W + FRAC_W;
  localparam int unsigned LATENCY  = 4 + (2 * DIM_W + FRAC_W + 1) / 2;
  localparam int unsigned WATCHDOG = 2000;
  localparam int unsigned PHASES   = 9;
  localparam int unsigned PHASE_REQUESTS = 205;

  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } rect_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [DIM_W-1:0]             source_width_i = '0;
  logic [DIM_W-1:0]             source_height_i = '0;
  logic signed [OFF_W-1:0]      span_offset_x_i = '0;
  logic signed [OFF_W-1:0]      span_offset_y_i = '0;
  logic [DIM_W-1:0]             span_width_i = '0;
  logic [DIM_W-1:0]             span_height_i = '0;
  logic                         done_o;
  logic signed [POS_W-1:0]      dest_x_o;
  logic signed [POS_W-1:0]      dest_y_o;
  logic [SIZE_W-1:0]            dest_width_o;
  logic [SIZE_W-1:0]            dest_height_o;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]        paddr = '0;
  logic [APB_DATA_W-1:0]        pwdata = '0;
  logic [APB_DATA_W-1:0]        prdata;
  logic                         pready;

  logic [MODE_W-1:0] cur_mode = MODE_ZOOM;
  rect_t             pending_rects[$];
  int unsigned       mismatch_count = 0;
  int unsigned       quiet_cycles = 0;
  bit                steady_run = 1'b0;

  image_fit_rect #(
    .DIM_BITS (DIM_W),
    .FRAC_BITS(FRAC_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .source_width_i (source_width_i),
    .source_height_i(source_height_i),
    .span_offset_x_i(span_offset_x_i),
    .span_offset_y_i(span_offset_y_i),
    .span_width_i   (span_width_i),
    .span_height_i  (span_height_i),
    .done_o         (done_o),
    .dest_x_o       (dest_x_o),
    .dest_y_o       (dest_y_o),
    .dest_width_o   (dest_width_o),
    .dest_height_o  (dest_height_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Destination rectangle for one request under the given fit mode.
  function automatic rect_t fit_rect(input logic [MODE_W-1:0] mode,
                                     input logic [DIM_W-1:0] sw, sh,
                                     input logic signed [OFF_W-1:0] ox, oy,
                                     input logic [DIM_W-1:0] pw, ph);
    longint w, h, x, y;
    logic   width_smaller, use_width;
    rect_t  r;
    if (sw == 0 || sh == 0 || mode == MODE_NONE || mode == MODE_TILED) return '0;
    case (mode)
      MODE_STRETCHED: begin
        w = longint'(pw) << FRAC_W;
        h = longint'(ph) << FRAC_W;
      end
      MODE_CENTERED: begin
        w = longint'(sw) << FRAC_W;
        h = longint'(sh) << FRAC_W;
      end
      default: begin
        // The width ratio is the smaller one when pw/sw <= ph/sh.
        width_smaller = longint'(pw) * longint'(sh) <= longint'(ph) * longint'(sw);
        use_width = (mode == MODE_SCALED) ? width_smaller : !width_smaller;
        if (use_width) begin
          w = longint'(pw) << FRAC_W;
          h = ((longint'(sh) * longint'(pw)) << FRAC_W) / longint'(sw);
        end else begin
          h = longint'(ph) << FRAC_W;
          w = ((longint'(sw) * longint'(ph)) << FRAC_W) / longint'(sh);
        end
      end
    endcase
    // An arithmetic shift halves with flooring, also for negative gaps.
    x = (((longint'(pw) << FRAC_W) - w) >>> 1) - (longint'(ox) <<< FRAC_W);
    y = (((longint'(ph) << FRAC_W) - h) >>> 1) - (longint'(oy) <<< FRAC_W);
    r.x = x[POS_W-1:0];
    r.y = y[POS_W-1:0];
    r.w = w[SIZE_W-1:0];
    r.h = h[SIZE_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string label, input logic [POS_W-1:0] want,
                             input logic [POS_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  // Result checking, request capture and the watchdog share the rising edge.
  always @(posedge clk_i) begin
    rect_t want;
    if (rst_ni && done_o) begin
      if (pending_rects.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, got %h %h %h %h",
                 $time, dest_x_o, dest_y_o, dest_width_o, dest_height_o);
        mismatch_count++;
      end else begin
        want = pending_rects.pop_front();
        check_field("dest_x", want.x, dest_x_o);
        check_field("dest_y", want.y, dest_y_o);
        check_field("dest_width", {1'b0, want.w}, {1'b0, dest_width_o});
        check_field("dest_height", {1'b0, want.h}, {1'b0, dest_height_o});
      end
    end
    if (rst_ni && start && !busy)
      pending_rects.push_back(fit_rect(cur_mode, source_width_i, source_height_i,
                                       span_offset_x_i, span_offset_y_i,
                                       span_width_i, span_height_i));
    if ((rst_ni && start && !busy) || done_o) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [DIM_W-1:0] sw, sh,
                              input logic signed [OFF_W-1:0] ox, oy,
                              input logic [DIM_W-1:0] pw, ph);
    int unsigned gap;
    gap = (!steady_run && $urandom_range(99) < 16) ? 1 : 0;
    repeat (gap) begin
      @(negedge clk_i);
      start           <= 1'b0;
      source_width_i  <= $urandom;
      source_height_i <= $urandom;
      span_offset_x_i <= $urandom;
      span_offset_y_i <= $urandom;
      span_width_i    <= $urandom;
      span_height_i   <= $urandom;
    end
    @(negedge clk_i);
    start           <= 1'b1;
    source_width_i  <= sw;
    source_height_i <= sh;
    span_offset_x_i <= ox;
    span_offset_y_i <= oy;
    span_width_i    <= pw;
    span_height_i   <= ph;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start and wait for every outstanding result.
  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk_i);
  endtask

  task automatic read_fit_mode(input logic [MODE_W-1:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_W'(4 * REG_FIT_MODE);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DATA_W'(want)) begin
      $display("%0t: fit_mode readback mismatch, expected %h, got %h",
               $time, APB_DATA_W'(want), prdata);
      mismatch_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_fit_mode(input logic [MODE_W-1:0] mode);
    wait_idle();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * REG_FIT_MODE);
    pwdata  <= APB_DATA_W'(mode);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cur_mode = mode;
    read_fit_mode(mode);
  endtask

  function automatic logic [DIM_W-1:0] rand_dim();
    case ($urandom_range(15)) inside
      0:       return '0;
      1:       return '1;
      [2:4]:   return DIM_W'($urandom_range(1, 64));
      [5:7]:   return DIM_W'($urandom_range(1, 2048));
      default: return DIM_W'($urandom);
    endcase
  endfunction

  task automatic test_reset_value();
    read_fit_mode(MODE_ZOOM);
  endtask

  // Zoom fill is active out of reset.
  task automatic test_directed_geometry();
    send_request(0, 100, 0, 0, 640, 480);
    send_request(100, 0, 0, 0, 640, 480);
    send_request('1, '1, 16'sh7fff, 16'sh7fff, '1, '1);
    send_request(640, 480, 16'sh8000, 16'sh8000, 1920, 1080);
    send_request(800, 600, 10, -10, 1600, 1200);
    send_request(1920, 1080, 0, 0, 0, 0);
    send_request(1, '1, 5, 5, '1, 1);
    send_request('1, 1, -1, -1, 1, '1);
    send_request(3, 7, 0, 0, 10, 10);
  endtask

  task automatic test_each_mode();
    logic [MODE_W-1:0] mode;
    for (int m = 0; m < (1 << MODE_W); m++) begin
      mode = MODE_W'(m);
      write_fit_mode(mode);
      send_request(1920, 1080, -100, 200, 1024, 768);
      send_request('1, 1, 16'sh7fff, 16'sh8000, 1, '1);
    end
  endtask

  task automatic test_random_geometry();
    logic [DIM_W-1:0] sw, sh, pw, ph;
    for (int p = 0; p < PHASES; p++) begin
      // The first eight phases visit every mode code once.
      write_fit_mode(p < 8 ? MODE_W'((p * 3) % 8) : MODE_W'($urandom_range(7)));
      steady_run = (p == 2);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        sw = rand_dim();
        sh = rand_dim();
        pw = rand_dim();
        ph = rand_dim();
        if ($urandom_range(7) == 0) begin
          pw = sw;
          ph = sh;
        end
        send_request(sw, sh, OFF_W'($urandom), OFF_W'($urandom), pw, ph);
      end
    end
    steady_run = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_value();
    test_directed_geometry();
    test_each_mode();
    test_random_geometry();
    wait_idle();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
